FILE: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/rblt_pkg.sv
// types and constants for the rectangle bin lookup table
package rblt_pkg;

  localparam int MAX_BINS    = 64;
  localparam int COORD_W     = 32;
  localparam int IDX_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);
  localparam int BIN_INDEX_W = 6;
  localparam int CFG_IDX_W   = 3;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] rect_x_low;
    logic signed [COORD_W-1:0] rect_x_high;
    logic signed [COORD_W-1:0] rect_y_low;
    logic signed [COORD_W-1:0] rect_y_high;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [BIN_INDEX_W-1:0] bin_index;
  } out_item_t;

  // search token that walks the cell row
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } tok_t;

endpackage

FILE: sv/rblt_cell.sv
// one table entry: holds a rectangle and tests the passing token's query against it
module rblt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [rblt_pkg::IDX_W-1:0] cell_idx,
  input  logic               active,
  input  rblt_pkg::in_item_t query,
  input  logic               wr_en,
  input  rblt_pkg::tok_t     tok_in,
  output rblt_pkg::tok_t     tok_out
);
  import rblt_pkg::*;

  logic signed [COORD_W-1:0] sxl_r, sxh_r, syl_r, syh_r;
  tok_t tok_r, tok_nxt;
  logic overlap, contain, hit_here;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sxl_r <= query.rect_x_low;
      sxh_r <= query.rect_x_high;
      syl_r <= query.rect_y_low;
      syh_r <= query.rect_y_high;
    end
  end

  // open intervals for overlap, closed edges for point containment
  always_comb begin
    overlap = !(($signed(query.rect_x_low) >= sxh_r) ||
                ($signed(query.rect_x_high) <= sxl_r) ||
                ($signed(query.rect_y_high) <= syl_r) ||
                ($signed(query.rect_y_low) >= syh_r));
    contain = ($signed(query.point_x) <= sxh_r) && ($signed(query.point_x) >= sxl_r) &&
              ($signed(query.point_y) <= syh_r) && ($signed(query.point_y) >= syl_r);
    hit_here = active && ((query.mode == MODE_ADD) ? overlap : contain);
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.hit && hit_here) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: sv/rectangle_bin_lookup_table_unit.sv
// rectangle bin lookup table: top level with control, region registers and cell row
// a taken start captures the query and sets launch_r; the search token then passes
// the registers of the MAX_BINS cells, and out_valid and the result are registered
// as it leaves the last cell; start is not taken while busy, which stays high while
// the search token walks the row of MAX_BINS cells, one cell per cycle
// reset (rst_n low, synchronous): table empty, full-range region; receiver cannot stall
module rectangle_bin_lookup_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rblt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output rblt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [rblt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rblt_pkg::COORD_W-1:0]   cfg_wdata
);
  import rblt_pkg::*;

  state_t state_r, state_nxt;
  in_item_t q_r;
  logic launch_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic signed [COORD_W-1:0] rxl_r, rxh_r, ryl_r, ryh_r;
  logic out_valid_r;
  out_item_t out_r, out_nxt;
  logic accept, finish, add_ok;
  logic outside, empty, full;
  logic out_err;
  tok_t tok [MAX_BINS+1];
  logic [MAX_BINS-1:0] tok_busy;
  logic [MAX_BINS-1:0] cell_active;
  logic [MAX_BINS-1:0] cell_wr;

  assign accept = start && !busy;
  assign finish = tok[MAX_BINS].valid;

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_RUN;
      S_RUN:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      S_IDLE:  busy = 1'b0;
      S_RUN:   busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r <= in_item;
    end
  end

  // region registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rxl_r <= {1'b1, {(COORD_W-1){1'b0}}};
      rxh_r <= {1'b0, {(COORD_W-1){1'b1}}};
      ryl_r <= {1'b1, {(COORD_W-1){1'b0}}};
      ryh_r <= {1'b0, {(COORD_W-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_LOW:  rxl_r <= cfg_wdata;
        REG_X_HIGH: rxh_r <= cfg_wdata;
        REG_Y_LOW:  ryl_r <= cfg_wdata;
        REG_Y_HIGH: ryh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // cell row, the token enters in the cycle after the query is captured
  always_comb begin
    tok[0].valid = launch_r;
    tok[0].hit   = 1'b0;
    tok[0].idx   = '0;
  end

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    assign cell_active[i] = (CNT_W'(i) < count_r);
    assign cell_wr[i]     = finish && add_ok && (count_r == CNT_W'(i));
    assign tok_busy[i]    = tok[i+1].valid;
    rblt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .active   (cell_active[i]),
      .query    (q_r),
      .wr_en    (cell_wr[i]),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // final classification when the token leaves the last cell
  always_comb begin
    outside = ($signed(q_r.rect_x_low) < rxl_r) || ($signed(q_r.rect_x_high) > rxh_r) ||
              ($signed(q_r.rect_y_low) < ryl_r) || ($signed(q_r.rect_y_high) > ryh_r);
    empty   = ($signed(q_r.rect_x_low) >= $signed(q_r.rect_x_high)) ||
              ($signed(q_r.rect_y_low) >= $signed(q_r.rect_y_high));
    full    = (count_r == CNT_W'(MAX_BINS));
    add_ok  = 1'b0;
    out_nxt.status    = ST_OK;
    out_nxt.bin_index = '0;
    if (q_r.mode == MODE_ADD) begin
      if (outside) begin
        out_nxt.status = ST_OUTSIDE;
      end else if (empty) begin
        out_nxt.status = ST_EMPTY;
      end else if (tok[MAX_BINS].hit) begin
        out_nxt.status = ST_OVERLAP;
      end else if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        add_ok = 1'b1;
        out_nxt.bin_index = BIN_INDEX_W'(count_r);
      end
    end else begin
      if (tok[MAX_BINS].hit) begin
        out_nxt.bin_index = BIN_INDEX_W'(tok[MAX_BINS].idx);
      end else begin
        out_nxt.status = ST_NOTFOUND;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (finish && add_ok) count_nxt = count_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_err   = out_valid && (out_item.status != ST_OK);

`include "assert_macros.svh"

  `ASSERT_NEXT(a_start_sets_busy, clk, rst_n, accept, busy)
  `ASSERT_IMPLY(a_strobe_when_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPLY(a_index_zero_on_error, clk, rst_n, out_err, out_item.bin_index == '0)
  `ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_BINS))
  `ASSERT_IMPLY(a_single_token, clk, rst_n, 1'b1, $onehot0(tok_busy))

endmodule
